// File: hdl/ple_pkg.sv
// shared types and codes for the positional list engine
package ple_pkg;

  localparam logic [2:0] ACT_INS_FRONT = 3'd0;
  localparam logic [2:0] ACT_INS_AT    = 3'd1;
  localparam logic [2:0] ACT_INS_BACK  = 3'd2;
  localparam logic [2:0] ACT_DEL_FRONT = 3'd3;
  localparam logic [2:0] ACT_DEL_AT    = 3'd4;
  localparam logic [2:0] ACT_DEL_BACK  = 3'd5;
  localparam logic [2:0] ACT_LENGTH    = 3'd6;
  localparam logic [2:0] ACT_LIST      = 3'd7;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  localparam logic [2:0] OP_NONE      = 3'd0;
  localparam logic [2:0] OP_INS_FRONT = 3'd1;
  localparam logic [2:0] OP_INS_AT    = 3'd2;
  localparam logic [2:0] OP_INS_BACK  = 3'd3;
  localparam logic [2:0] OP_DEL_FRONT = 3'd4;
  localparam logic [2:0] OP_DEL_AT    = 3'd5;
  localparam logic [2:0] OP_DEL_BACK  = 3'd6;
  localparam logic [2:0] OP_ROTATE    = 3'd7;

  localparam int ListMax = 16;

  typedef struct packed {
    logic [2:0] op;
    logic       load_out;
    logic [1:0] status;
    logic       last;
    logic       show_head;
  } ple_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic ins_pos_ok;
    logic del_pos_ok;
    logic out_free;
  } ple_sts_t;

endpackage

// File: hdl/ple_ctrl.sv
// request decoder and listing sequencer
module ple_ctrl
  import ple_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic [2:0]                         in_action,
  output logic                               in_stall,
  input  logic [$clog2(CAPACITY+1)-1:0]      count,
  input  ple_sts_t                           sts,
  output ple_cmd_t                           cmd
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = ((CW > 5) ? CW : 5) + 1;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_LIST = 1'b1;

  logic          state_r, state_nxt;
  logic [CW-1:0] rot_r, rot_nxt;
  logic [4:0]    emit_r, emit_nxt;
  logic [PW-1:0] cnt_p;
  logic [4:0]    nshow;
  logic          rot_end;

  assign cnt_p   = PW'(count);
  assign nshow   = (cnt_p > PW'(ListMax)) ? 5'(ListMax) : 5'(cnt_p);
  assign rot_end = (rot_r + CW'(1)) == count;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    rot_nxt   = rot_r;
    emit_nxt  = emit_r;
    in_stall  = !((state_r == S_IDLE) && sts.out_free);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd.load_out = 1'b1;
          cmd.last     = 1'b1;
          cmd.status   = ST_OK;
          unique case (in_action)
            ACT_INS_FRONT: begin
              if (sts.full) cmd.status = ST_FULL;
              else cmd.op = OP_INS_FRONT;
            end
            ACT_INS_AT: begin
              if (sts.full) cmd.status = ST_FULL;
              else if (!sts.ins_pos_ok) cmd.status = ST_INVALID;
              else cmd.op = OP_INS_AT;
            end
            ACT_INS_BACK: begin
              if (sts.full) cmd.status = ST_FULL;
              else cmd.op = OP_INS_BACK;
            end
            ACT_DEL_FRONT: begin
              if (sts.empty) cmd.status = ST_EMPTY;
              else cmd.op = OP_DEL_FRONT;
            end
            ACT_DEL_AT: begin
              if (sts.empty) cmd.status = ST_EMPTY;
              else if (!sts.del_pos_ok) cmd.status = ST_INVALID;
              else cmd.op = OP_DEL_AT;
            end
            ACT_DEL_BACK: begin
              if (sts.empty) cmd.status = ST_EMPTY;
              else cmd.op = OP_DEL_BACK;
            end
            ACT_LENGTH: begin
              cmd.status = ST_OK;
            end
            ACT_LIST: begin
              if (sts.empty) begin
                cmd.status = ST_EMPTY;
              end else begin
                cmd.load_out = 1'b0;
                state_nxt    = S_LIST;
                rot_nxt      = '0;
                emit_nxt     = '0;
              end
            end
            default: cmd.status = ST_OK;
          endcase
        end
      end
      S_LIST: begin
        // rotate the list once round, showing the head while beats remain
        if (emit_r < nshow) begin
          if (sts.out_free) begin
            cmd.op        = OP_ROTATE;
            cmd.load_out  = 1'b1;
            cmd.show_head = 1'b1;
            cmd.status    = ST_OK;
            cmd.last      = (emit_r + 5'd1) == nshow;
            emit_nxt      = emit_r + 5'd1;
            rot_nxt       = rot_r + CW'(1);
            if (rot_end) state_nxt = S_IDLE;
          end
        end else begin
          cmd.op  = OP_ROTATE;
          rot_nxt = rot_r + CW'(1);
          if (rot_end) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rot_r   <= '0;
      emit_r  <= '0;
    end else begin
      state_r <= state_nxt;
      rot_r   <= rot_nxt;
      emit_r  <= emit_nxt;
    end
  end

endmodule

// File: hdl/ple_datapath.sv
// shift-cell list storage, entry count and result register
module ple_datapath
  import ple_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [4:0]                    in_position,
  input  logic signed [31:0]            in_item_value,
  input  ple_cmd_t                      cmd,
  output ple_sts_t                      sts,
  output logic [$clog2(CAPACITY+1)-1:0] count,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_status,
  output logic [4:0]                    out_length,
  output logic signed [31:0]            out_entry_value,
  output logic                          out_last
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = ((CW > 5) ? CW : 5) + 1;

  logic [31:0]   cell_r   [CAPACITY];
  logic [31:0]   cell_nxt [CAPACITY];
  logic [CW-1:0] count_r, count_nxt;
  logic [PW-1:0] cnt_p, pos_p, ins_k, del_k;
  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic [4:0]    out_length_r;
  logic [31:0]   out_entry_r;
  logic          out_last_r;

  assign cnt_p = PW'(count_r);
  assign pos_p = PW'(in_position);

  always_comb begin
    case (cmd.op)
      OP_INS_AT:   ins_k = pos_p - PW'(1);
      OP_INS_BACK: ins_k = cnt_p;
      default:     ins_k = '0;
    endcase
    case (cmd.op)
      OP_DEL_AT:   del_k = pos_p - PW'(1);
      OP_DEL_BACK: del_k = cnt_p - PW'(1);
      default:     del_k = '0;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    for (int i = 0; i < CAPACITY; i++) begin
      cell_nxt[i] = cell_r[i];
      case (cmd.op)
        OP_INS_FRONT, OP_INS_AT, OP_INS_BACK: begin
          if (PW'(i) == ins_k) cell_nxt[i] = in_item_value;
          else if (PW'(i) > ins_k && i > 0) cell_nxt[i] = cell_r[(i > 0) ? i - 1 : 0];
        end
        OP_DEL_FRONT, OP_DEL_AT, OP_DEL_BACK: begin
          if (PW'(i) >= del_k && i < CAPACITY - 1)
            cell_nxt[i] = cell_r[(i < CAPACITY - 1) ? i + 1 : i];
        end
        OP_ROTATE: begin
          if (PW'(i + 1) < cnt_p) cell_nxt[i] = cell_r[(i < CAPACITY - 1) ? i + 1 : i];
          else if (PW'(i + 1) == cnt_p) cell_nxt[i] = cell_r[0];
        end
        default: cell_nxt[i] = cell_r[i];
      endcase
    end
    case (cmd.op)
      OP_INS_FRONT, OP_INS_AT, OP_INS_BACK: count_nxt = count_r + CW'(1);
      OP_DEL_FRONT, OP_DEL_AT, OP_DEL_BACK: count_nxt = count_r - CW'(1);
      default:                              count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) cell_r[i] <= cell_nxt[i];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cmd.load_out) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r <= cmd.status;
      out_length_r <= 5'(count_nxt);
      out_entry_r  <= cmd.show_head ? cell_r[0] : 32'd0;
      out_last_r   <= cmd.last;
    end
  end

  assign sts.empty      = (count_r == '0);
  assign sts.full       = (count_r == CW'(CAPACITY));
  assign sts.ins_pos_ok = (pos_p >= PW'(1)) && (pos_p <= cnt_p + PW'(1));
  assign sts.del_pos_ok = (pos_p >= PW'(1)) && (pos_p <= cnt_p);
  assign sts.out_free   = !out_valid_r || !out_stall;

  assign count           = count_r;
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_length      = out_length_r;
  assign out_entry_value = out_entry_r;
  assign out_last        = out_last_r;

endmodule

// File: hdl/positional_list_engine_core.sv
// top level of the positional list engine
// Bounded ordered list of signed 32-bit values held in CAPACITY shift cells, front
// in cell 0. Inserts, deletes and length reports each give one result beat,
// registered, the cycle after the request beat is taken; the next request may be
// taken at the edge that hands that beat on, but not while it is held by
// out_stall. A listing rotates the cells once round the current entries, one cell
// step per cycle unless a beat is held by out_stall, emitting the front cell as a
// beat on each of the first min(length, 16) steps; it occupies the block until
// the rotation ends, and no request is taken meanwhile. Listing an empty list
// gives one beat with empty status instead. Cells need no clearing after reset.
module positional_list_engine_core
  import ple_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_action,
  input  logic [4:0]         in_position,
  input  logic signed [31:0] in_item_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [4:0]         out_length,
  output logic signed [31:0] out_entry_value,
  output logic               out_last
);

  localparam int CW = $clog2(CAPACITY + 1);

  ple_cmd_t      cmd;
  ple_sts_t      sts;
  logic [CW-1:0] count;

  ple_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_action(in_action),
    .in_stall (in_stall),
    .count    (count),
    .sts      (sts),
    .cmd      (cmd)
  );

  ple_datapath #(.CAPACITY(CAPACITY)) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_position    (in_position),
    .in_item_value  (in_item_value),
    .cmd            (cmd),
    .sts            (sts),
    .count          (count),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_length     (out_length),
    .out_entry_value(out_entry_value),
    .out_last       (out_last)
  );

  // a listing still in progress holds off requests
  a_list_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> in_stall)
    else $error("request taken in the middle of a listing");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> out_last)
    else $error("error status on a beat that is not last");

  a_entry_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_entry_value != 32'sd0) |-> (out_status == ST_OK))
    else $error("entry value on a beat with error status");

endmodule

// File: dv/testbench.sv
// testbench for the positional list engine: directed table, random traffic, shadow list predictor
`timescale 1ns / 1ps

module testbench;
  import ple_pkg::*;

  localparam int CAP         = 16;
  localparam int RAND_N      = 412;
  localparam int LIMIT       = 600000;
  localparam int HOLD_CYCLES = 300;
  localparam int N_ROWS      = 28;

  typedef struct packed {
    logic [1:0]         status;
    logic [4:0]         length;
    logic signed [31:0] entry_value;
    logic               last;
  } list_beat_t;

  typedef struct {
    logic [2:0]  act;
    logic [4:0]  pos;
    logic [31:0] val;
    int          reps;
    bit          chk;
    logic [1:0]  st;
    logic [4:0]  len;
  } list_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [2:0]         in_action = ACT_LENGTH;
  logic [4:0]         in_position = 5'd0;
  logic signed [31:0] in_item_value = 32'sd0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         out_status;
  logic [4:0]         out_length;
  logic signed [31:0] out_entry_value;
  logic               out_last;

  logic signed [31:0] shadow_cells[$];
  list_beat_t         expected_beats[$];
  int                 errors = 0;
  int                 in_taken = 0;
  int                 calm_from = 0;
  int                 hold_at = 0;
  int                 cycles = 0;
  int                 stall_left = 0;
  int                 hold_left = 0;
  bit                 held = 1'b0;

  list_row_t list_rows [N_ROWS] = '{
    '{ACT_DEL_FRONT, 5'd0,  32'h0,        1,  1'b1, ST_EMPTY,   5'd0},
    '{ACT_DEL_AT,    5'd1,  32'h0,        1,  1'b1, ST_EMPTY,   5'd0},
    '{ACT_DEL_BACK,  5'd31, 32'h0,        1,  1'b1, ST_EMPTY,   5'd0},
    '{ACT_LIST,      5'd0,  32'h0,        1,  1'b1, ST_EMPTY,   5'd0},
    '{ACT_LENGTH,    5'd7,  32'h0,        1,  1'b1, ST_OK,      5'd0},
    '{ACT_INS_AT,    5'd0,  32'h1,        1,  1'b1, ST_INVALID, 5'd0},
    '{ACT_INS_AT,    5'd2,  32'h1,        1,  1'b1, ST_INVALID, 5'd0},
    '{ACT_INS_AT,    5'd1,  32'h7fffffff, 1,  1'b1, ST_OK,      5'd1},
    '{ACT_INS_FRONT, 5'd31, 32'h80000000, 1,  1'b1, ST_OK,      5'd2},
    '{ACT_INS_BACK,  5'd0,  32'hffffffff, 1,  1'b1, ST_OK,      5'd3},
    '{ACT_LIST,      5'd0,  32'h0,        1,  1'b0, ST_OK,      5'd0},
    '{ACT_INS_AT,    5'd4,  32'h0,        1,  1'b1, ST_OK,      5'd4},
    '{ACT_INS_AT,    5'd31, 32'h5,        1,  1'b1, ST_INVALID, 5'd4},
    '{ACT_INS_AT,    5'd2,  32'h12345678, 1,  1'b0, ST_OK,      5'd0},
    '{ACT_INS_BACK,  5'd0,  32'haaaaaaaa, 11, 1'b0, ST_OK,      5'd0},
    '{ACT_INS_FRONT, 5'd0,  32'h55555555, 1,  1'b1, ST_FULL,    5'd16},
    '{ACT_INS_AT,    5'd0,  32'h55555555, 1,  1'b1, ST_FULL,    5'd16},
    '{ACT_INS_BACK,  5'd0,  32'h55555555, 1,  1'b1, ST_FULL,    5'd16},
    '{ACT_LENGTH,    5'd31, 32'hffffffff, 1,  1'b1, ST_OK,      5'd16},
    '{ACT_LIST,      5'd0,  32'h0,        1,  1'b0, ST_OK,      5'd0},
    '{ACT_DEL_AT,    5'd0,  32'h0,        1,  1'b1, ST_INVALID, 5'd16},
    '{ACT_DEL_AT,    5'd17, 32'h0,        1,  1'b1, ST_INVALID, 5'd16},
    '{ACT_DEL_AT,    5'd16, 32'h0,        1,  1'b1, ST_OK,      5'd15},
    '{ACT_DEL_AT,    5'd1,  32'h0,        1,  1'b1, ST_OK,      5'd14},
    '{ACT_DEL_AT,    5'd7,  32'h0,        1,  1'b0, ST_OK,      5'd0},
    '{ACT_DEL_FRONT, 5'd0,  32'h0,        1,  1'b1, ST_OK,      5'd12},
    '{ACT_DEL_BACK,  5'd0,  32'h0,        1,  1'b1, ST_OK,      5'd11},
    '{ACT_LIST,      5'd0,  32'h0,        1,  1'b0, ST_OK,      5'd0}
  };

  positional_list_engine_core #(.CAPACITY(CAP)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_position     (in_position),
    .in_item_value   (in_item_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_length      (out_length),
    .out_entry_value (out_entry_value),
    .out_last        (out_last)
  );

  always #6 clk = ~clk;

  function automatic void predict_list_step(input logic [2:0] act, input logic [4:0] pos,
                                            input logic signed [31:0] val);
    int         n;
    int         shown;
    logic [1:0] st;
    n  = shadow_cells.size();
    st = ST_OK;
    case (act)
      ACT_INS_FRONT, ACT_INS_AT, ACT_INS_BACK: begin
        if (n >= CAP) st = ST_FULL;
        else if (act == ACT_INS_FRONT) shadow_cells.push_front(val);
        else if (act == ACT_INS_BACK) shadow_cells.push_back(val);
        else if (pos < 1 || pos > n + 1) st = ST_INVALID;
        else shadow_cells.insert(pos - 1, val);
      end
      ACT_DEL_FRONT, ACT_DEL_AT, ACT_DEL_BACK: begin
        if (n == 0) st = ST_EMPTY;
        else if (act == ACT_DEL_FRONT) shadow_cells.delete(0);
        else if (act == ACT_DEL_BACK) shadow_cells.delete(n - 1);
        else if (pos < 1 || pos > n) st = ST_INVALID;
        else shadow_cells.delete(pos - 1);
      end
      ACT_LENGTH: ;
      ACT_LIST: begin
        if (n == 0) begin
          expected_beats.push_back('{ST_EMPTY, 5'd0, 32'sd0, 1'b1});
        end else begin
          shown = (n > 16) ? 16 : n;
          for (int i = 0; i < shown; i++)
            expected_beats.push_back('{ST_OK, 5'(n), shadow_cells[i], i == shown - 1});
        end
        return;
      end
    endcase
    expected_beats.push_back('{st, 5'(shadow_cells.size()), 32'sd0, 1'b1});
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return 32'h7fffffff;
      1:       return 32'h80000000;
      2:       return 32'h0;
      3:       return 32'hffffffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_beat(input logic [2:0] act, input logic [4:0] pos, input logic [31:0] val,
                           input bit chk, input logic [1:0] st, input logic [4:0] len);
    if (in_taken < calm_from && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= act;
    in_position   <= pos;
    in_item_value <= val;
    do @(posedge clk); while (in_stall);
    in_taken++;
    predict_list_step(act, pos, val);
    if (chk) expected_beats[expected_beats.size() - 1] = '{st, len, 32'sd0, 1'b1};
    @(negedge clk);
  endtask

  // receiver: random stall bursts, one long hold-off, calm at the end
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!held && in_taken >= hold_at) begin
      held = 1'b1;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (in_taken < calm_from && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 11);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    list_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_beats.size() == 0) begin
        errors++;
        $display("%0t unexpected beat: got st=%0d len=%0d val=%0h last=%0b", $time,
                 out_status, out_length, out_entry_value, out_last);
      end else begin
        want = expected_beats.pop_front();
        if (want.status !== out_status || want.length !== out_length ||
            want.entry_value !== out_entry_value || want.last !== out_last) begin
          errors++;
          $display({"%0t mismatch: expected st=%0d len=%0d val=%0h last=%0b, ",
                    "got st=%0d len=%0d val=%0h last=%0b"},
                   $time, want.status, want.length, want.entry_value, want.last,
                   out_status, out_length, out_entry_value, out_last);
        end
      end
    end
  end

  initial begin
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL positional_list_engine_core");
    $finish;
  end

  initial begin
    int         n_dir;
    int         mode;
    int         n;
    int         r;
    int         sub;
    bit         grow;
    logic [2:0] act;
    logic [4:0] pos;
    n_dir = 0;
    foreach (list_rows[i]) n_dir += list_rows[i].reps;
    calm_from = n_dir + RAND_N - 60;
    hold_at   = n_dir + 30;
    mode      = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (list_rows[i])
      repeat (list_rows[i].reps)
        send_beat(list_rows[i].act, list_rows[i].pos, list_rows[i].val,
                  list_rows[i].chk, list_rows[i].st, list_rows[i].len);

    for (int k = 0; k < RAND_N; k++) begin
      if (k % 40 == 0) mode = $urandom_range(0, 2);
      n = shadow_cells.size();
      r = $urandom_range(0, 99);
      if (r < 9) begin
        act = ACT_LIST;
      end else if (r < 13) begin
        act = ACT_LENGTH;
      end else begin
        grow = $urandom_range(0, 99) < ((mode == 0) ? 75 : (mode == 1) ? 25 : 50);
        sub  = $urandom_range(0, 2);
        act  = grow ? ACT_INS_FRONT + 3'(sub) : ACT_DEL_FRONT + 3'(sub);
      end
      if ($urandom_range(0, 3) == 0) pos = 5'($urandom_range(0, 31));
      else if (act <= ACT_INS_BACK) pos = 5'($urandom_range(1, n + 1));
      else if (n > 0) pos = 5'($urandom_range(1, n));
      else pos = 5'($urandom_range(0, 31));
      send_beat(act, pos, pick_value(), 1'b0, ST_OK, 5'd0);
    end
    in_valid <= 1'b0;

    while (expected_beats.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("PASS positional_list_engine_core");
    end else begin
      $display("FAIL positional_list_engine_core");
    end
    $finish;
  end

endmodule
